FILE: rtl/lsis_pkg.sv
// ----------------------------------------------------------------------------
// lsis_pkg
// Shared types and constants for the line start index search block.
// ----------------------------------------------------------------------------
package lsis_pkg;

  localparam int unsigned LSIS_MAX_LINES = 4096;

  localparam int unsigned LSIS_OFFSET_W = 32;
  localparam int unsigned LSIS_LINE_W   = 12;
  localparam int unsigned LSIS_COUNT_W  = 13;

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOCATE = 2'd2,
    OP_QUERY  = 2'd3
  } lsis_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } lsis_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } lsis_state_t;

  // Port controls of the offset table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lsis_mem_ctl_t;

endpackage

FILE: rtl/lsis_table.sv
// ----------------------------------------------------------------------------
// lsis_table
// Line start offset table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsis_table #(
  parameter int unsigned DEPTH = lsis_pkg::LSIS_MAX_LINES,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  lsis_pkg::lsis_mem_ctl_t             mem_ctl,
  input  logic [IW-1:0]                       rd_addr,
  input  logic [IW-1:0]                       wr_addr,
  input  logic [lsis_pkg::LSIS_OFFSET_W-1:0]  wr_data,
  output logic [lsis_pkg::LSIS_OFFSET_W-1:0]  rd_data
);
  import lsis_pkg::*;

  logic [LSIS_OFFSET_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lsis_ctrl.sv
// ----------------------------------------------------------------------------
// lsis_ctrl
// Request sequencer: entry count, table updates, the binary search loop and
// the output register.
// ----------------------------------------------------------------------------
module lsis_ctrl #(
  parameter int unsigned MAX_LINES = lsis_pkg::LSIS_MAX_LINES,
  parameter int unsigned IW        = $clog2(MAX_LINES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          op,
  input  logic [lsis_pkg::LSIS_OFFSET_W-1:0]  position,
  input  logic [lsis_pkg::LSIS_LINE_W-1:0]    line_number,
  input  logic [lsis_pkg::LSIS_OFFSET_W-1:0]  file_size,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [lsis_pkg::LSIS_LINE_W-1:0]    found_line,
  output logic [lsis_pkg::LSIS_OFFSET_W-1:0]  line_start,
  output logic [lsis_pkg::LSIS_COUNT_W-1:0]   line_count,
  output logic [1:0]                          status,
  output lsis_pkg::lsis_mem_ctl_t             mem_ctl,
  output logic [IW-1:0]                       rd_addr,
  output logic [IW-1:0]                       wr_addr,
  output logic [lsis_pkg::LSIS_OFFSET_W-1:0]  wr_data,
  input  logic [lsis_pkg::LSIS_OFFSET_W-1:0]  rd_data
);
  import lsis_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LINES + 1);
  localparam int unsigned QW = (CW > LSIS_LINE_W) ? CW : LSIS_LINE_W;

  lsis_state_t              state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            lo, lo_next;
  logic [CW-1:0]            hi, hi_next;
  logic [CW-1:0]            mid, mid_next;
  logic [LSIS_OFFSET_W-1:0] pos, pos_next;
  logic [LSIS_LINE_W-1:0]   res_line, res_line_next;
  logic [LSIS_OFFSET_W-1:0] res_start, res_start_next;
  lsis_status_t             res_status, res_status_next;
  logic                     use_mem, use_mem_next;

  logic          accept;
  logic          out_free;
  logic          full;
  logic          le;
  logic [CW-1:0] lo_step;
  logic [CW-1:0] hi_step;
  logic          more;
  logic [CW-1:0] last_line;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign full      = (count == CW'(MAX_LINES));

  // One probe of the search: the table word at mid arrived this cycle.
  assign le        = (rd_data <= pos);
  assign lo_step   = le ? (mid + CW'(1)) : lo;
  assign hi_step   = le ? hi : mid;
  assign more      = (lo_step < hi_step);
  assign last_line = (lo_step == '0) ? '0 : (lo_step - CW'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((lsis_op_t'(op) == OP_LOCATE) && (count != '0)) begin
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SEARCH: begin
        if (!more) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl         = '0;
    rd_addr         = '0;
    wr_addr         = count[IW-1:0];
    wr_data         = position;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    pos_next        = pos;
    res_line_next   = res_line;
    res_start_next  = res_start;
    res_status_next = res_status;
    use_mem_next    = use_mem;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_line_next   = '0;
          res_start_next  = '0;
          res_status_next = STAT_OK;
          use_mem_next    = 1'b0;
          case (lsis_op_t'(op))
            OP_MARK: begin
              if (full) begin
                res_status_next = STAT_FULL;
              end else begin
                mem_ctl.wr_en  = 1'b1;
                count_next     = count + CW'(1);
                res_line_next  = LSIS_LINE_W'(count);
                res_start_next = position;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_LOCATE: begin
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
              end else begin
                lo_next       = '0;
                hi_next       = count;
                mid_next      = count >> 1;
                pos_next      = position;
                mem_ctl.rd_en = 1'b1;
                rd_addr       = IW'(count >> 1);
              end
            end
            OP_QUERY: begin
              res_line_next = line_number;
              if (QW'(line_number) < QW'(count)) begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = IW'(line_number);
                use_mem_next  = 1'b1;
              end else begin
                res_start_next = file_size;
              end
            end
            default: begin
              res_status_next = STAT_OK;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        lo_next       = lo_step;
        hi_next       = hi_step;
        mem_ctl.rd_en = 1'b1;
        if (more) begin
          mid_next = lo_step + ((hi_step - lo_step) >> 1);
          rd_addr  = IW'(lo_step + ((hi_step - lo_step) >> 1));
        end else begin
          // The search has ended; fetch the start of the line found.
          rd_addr       = IW'(last_line);
          res_line_next = LSIS_LINE_W'(last_line);
          use_mem_next  = 1'b1;
        end
      end
      default: begin
        use_mem_next = use_mem;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    pos        <= pos_next;
    res_line   <= res_line_next;
    res_start  <= res_start_next;
    res_status <= res_status_next;
    use_mem    <= use_mem_next;
  end

  // The read data register holds still in the result state, since no read
  // is issued there.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      found_line <= res_line;
      line_start <= use_mem ? rd_data : res_start;
      line_count <= LSIS_COUNT_W'(count);
      status     <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("table read and write issued in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LINES))
    else $error("entry count beyond table depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo < hi) && (mid >= lo) && (mid < hi))
    else $error("search probe outside its window");

  a_result_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT) && ($past(state) != ST_RESULT) && use_mem
      |-> $past(mem_ctl.rd_en))
    else $error("result taken from table without a read");
`endif

endmodule

FILE: rtl/line_start_index_search.sv
// ----------------------------------------------------------------------------
// line_start_index_search
// Ascending table of line start offsets with mark, clear, locate and query.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Mark, clear and query requests, and a
// locate on an empty table, go from acceptance straight to the result state,
// and the next request can be accepted once that result has entered the
// output register. A locate on a table of N entries makes at most
// ceil(log2(N + 1)) binary search probes, one per cycle, set by the single
// read port of the offset table. It then fetches the start of the line found
// from the table. A finished result waits in the output register while the
// next request is accepted. A result that cannot enter a stalled output
// register holds the block in its result state. The table holds no reset
// value; only entries that a mark has written are ever used in a result.
module line_start_index_search #(
  parameter int unsigned MAX_LINES = lsis_pkg::LSIS_MAX_LINES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lsis_pkg::LSIS_OFFSET_W-1:0]  cfg_wr_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          op,
  input  logic [lsis_pkg::LSIS_OFFSET_W-1:0]  position,
  input  logic [lsis_pkg::LSIS_LINE_W-1:0]    line_number,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [lsis_pkg::LSIS_LINE_W-1:0]    found_line,
  output logic [lsis_pkg::LSIS_OFFSET_W-1:0]  line_start,
  output logic [lsis_pkg::LSIS_COUNT_W-1:0]   line_count,
  output logic [1:0]                          status
);
  import lsis_pkg::*;

  localparam int unsigned IW = $clog2(MAX_LINES);

  logic [LSIS_OFFSET_W-1:0] file_size;
  lsis_mem_ctl_t            mem_ctl;
  logic [IW-1:0]            rd_addr;
  logic [IW-1:0]            wr_addr;
  logic [LSIS_OFFSET_W-1:0] wr_data;
  logic [LSIS_OFFSET_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg_wr_en) begin
      file_size <= cfg_wr_data;
    end
  end

  lsis_ctrl #(
    .MAX_LINES (MAX_LINES),
    .IW        (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .op          (op),
    .position    (position),
    .line_number (line_number),
    .file_size   (file_size),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .found_line  (found_line),
    .line_start  (line_start),
    .line_count  (line_count),
    .status      (status),
    .mem_ctl     (mem_ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data)
  );

  lsis_table #(
    .DEPTH (MAX_LINES),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

FILE: tb/sv/tb_line_start_index_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_start_index_search
// Self-checking bench for the line start offset table. A scoreboard keeps a
// shadow copy of the table, predicts the response of every accepted request
// and compares each response field by field. Stimulus is a directed set of
// corner requests, a long run of ascending marks with searches over it, then
// random request streams under several sender gap and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_line_start_index_search;
  import lsis_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned FILL_LINES  = 300;

  typedef struct {
    lsis_op_t                 op;
    logic [LSIS_OFFSET_W-1:0] position;
    logic [LSIS_LINE_W-1:0]   line_number;
  } line_req_t;

  typedef struct {
    logic [LSIS_LINE_W-1:0]   found_line;
    logic [LSIS_OFFSET_W-1:0] line_start;
    logic [LSIS_COUNT_W-1:0]  line_count;
    logic [1:0]               status;
  } line_rsp_t;

  class line_table_scoreboard;
    logic [LSIS_OFFSET_W-1:0] starts [LSIS_MAX_LINES];
    int unsigned              count = 0;
    logic [LSIS_OFFSET_W-1:0] file_size = '0;
    line_rsp_t                expected_rsp [$];
    int unsigned              errors = 0;

    task report(string what, logic [31:0] seen, logic [31:0] want);
      errors++;
      if (errors <= 100)
        $display("[%0t] %s mismatch: saw 0x%0h, expected 0x%0h", $time, what, seen, want);
    endtask

    // Predict the response of one accepted request and update the shadow table.
    task note_request(line_req_t r);
      line_rsp_t   e;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned line;
      e.found_line = '0;
      e.line_start = '0;
      e.status     = STAT_OK;
      case (r.op)
        OP_MARK: begin
          if (count >= LSIS_MAX_LINES) begin
            e.status = STAT_FULL;
          end else begin
            starts[count] = r.position;
            e.found_line  = LSIS_LINE_W'(count);
            e.line_start  = r.position;
            count++;
          end
        end
        OP_CLEAR: count = 0;
        OP_LOCATE: begin
          if (count == 0) begin
            e.status = STAT_EMPTY;
          end else begin
            lo = 0;
            hi = count;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (starts[mid] <= r.position) lo = mid + 1;
              else hi = mid;
            end
            // A position ahead of the first start still reports line zero.
            line = (lo == 0) ? 0 : lo - 1;
            e.found_line = LSIS_LINE_W'(line);
            e.line_start = starts[line];
          end
        end
        default: begin
          e.found_line = r.line_number;
          e.line_start = (r.line_number < count) ? starts[r.line_number] : file_size;
        end
      endcase
      e.line_count = LSIS_COUNT_W'(count);
      expected_rsp = {expected_rsp, e};
    endtask

    task check_result(line_rsp_t seen);
      line_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report("unexpected response", seen.line_start, 0);
      end else begin
        want = expected_rsp.pop_front();
        if (seen.found_line !== want.found_line)
          report("found_line", seen.found_line, want.found_line);
        if (seen.line_start !== want.line_start)
          report("line_start", seen.line_start, want.line_start);
        if (seen.line_count !== want.line_count)
          report("line_count", seen.line_count, want.line_count);
        if (seen.status !== want.status)
          report("status", seen.status, want.status);
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [LSIS_OFFSET_W-1:0] cfg_wr_data;
  logic                     req_valid;
  logic                     req_stall;
  logic [1:0]               op;
  logic [LSIS_OFFSET_W-1:0] position;
  logic [LSIS_LINE_W-1:0]   line_number;
  logic                     rsp_valid;
  logic                     rsp_stall;
  logic [LSIS_LINE_W-1:0]   found_line;
  logic [LSIS_OFFSET_W-1:0] line_start;
  logic [LSIS_COUNT_W-1:0]  line_count;
  logic [1:0]               status;

  line_table_scoreboard sb;
  int unsigned          gap_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          cycle_cnt = 0;

  line_start_index_search dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .op          (op),
    .position    (position),
    .line_number (line_number),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .found_line  (found_line),
    .line_start  (line_start),
    .line_count  (line_count),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit coin(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver: stall is chosen at the falling edge, responses taken at the rising edge.
  initial begin
    forever begin
      @(negedge clk);
      rsp_stall = coin(stall_pct);
    end
  end

  initial begin
    line_rsp_t seen;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        seen.found_line = found_line;
        seen.line_start = line_start;
        seen.line_count = line_count;
        seen.status     = status;
        sb.check_result(seen);
      end
    end
  end

  // Called and returns at a falling edge. Valid stays high after acceptance
  // unless the next request starts with a gap.
  task automatic send(line_req_t r);
    while (coin(gap_pct)) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid   = 1'b1;
    op          = r.op;
    position    = r.position;
    line_number = r.line_number;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_op(lsis_op_t o, logic [31:0] pos, logic [11:0] ln);
    line_req_t r;
    r.op          = o;
    r.position    = pos;
    r.line_number = ln;
    send(r);
  endtask

  // Stop sending and wait for every outstanding response.
  task automatic drain();
    req_valid = 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_file_size(logic [31:0] value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.file_size = value;
  endtask

  task automatic directed_requests();
    write_file_size(32'hFFFF_FFFF);
    send_op(OP_LOCATE, 32'h0, 12'd0);
    send_op(OP_LOCATE, 32'hFFFF_FFFF, 12'hFFF);
    send_op(OP_QUERY, 32'h0, 12'd0);
    send_op(OP_QUERY, 32'h0, 12'hFFF);
    send_op(OP_CLEAR, 32'h0, 12'd0);
    send_op(OP_MARK, 32'h0, 12'd0);
    send_op(OP_MARK, 32'd100, 12'd0);
    send_op(OP_MARK, 32'd100, 12'd0);
    send_op(OP_MARK, 32'hFFFF_FFFF, 12'd0);
    send_op(OP_LOCATE, 32'h0, 12'd0);
    send_op(OP_LOCATE, 32'd99, 12'd0);
    send_op(OP_LOCATE, 32'd100, 12'd0);
    send_op(OP_LOCATE, 32'hFFFF_FFFE, 12'd0);
    send_op(OP_LOCATE, 32'hFFFF_FFFF, 12'd0);
    send_op(OP_QUERY, 32'h0, 12'd3);
    send_op(OP_QUERY, 32'h0, 12'd4);
    send_op(OP_CLEAR, 32'hFFFF_FFFF, 12'hFFF);
    // The first start is not zero, so a low position lands ahead of it.
    send_op(OP_MARK, 32'd50, 12'd0);
    send_op(OP_LOCATE, 32'd10, 12'd0);
    send_op(OP_MARK, 32'd30, 12'd0);
    send_op(OP_LOCATE, 32'd40, 12'd0);
    send_op(OP_MARK, 32'hAAAA_5555, 12'd0);
    send_op(OP_QUERY, 32'h0, 12'hFFF);
    send_op(OP_LOCATE, 32'hAAAA_5555, 12'd0);
    send_op(OP_CLEAR, 32'h0, 12'd0);
    drain();
  endtask

  // Fill a long run of entries in ascending order, append a few unordered
  // marks, then search and query the table.
  task automatic fill_table_phase();
    logic [31:0] off;
    int unsigned k;
    gap_pct   = 8;
    stall_pct = 8;
    write_file_size(32'h5555_AAAA);
    send_op(OP_CLEAR, 32'h0, 12'd0);
    off = 32'd0;
    for (int i = 0; i < FILL_LINES; i++) begin
      send_op(OP_MARK, (i == FILL_LINES - 1) ? 32'hFFFF_FFFF : off, 12'(i));
      if (!coin(5)) off += $urandom_range(1_000_000);
    end
    repeat (3) send_op(OP_MARK, $urandom, 12'($urandom));
    send_op(OP_LOCATE, 32'h0, 12'd0);
    send_op(OP_LOCATE, 32'hFFFF_FFFF, 12'd0);
    repeat (60) begin
      k = $urandom_range(FILL_LINES - 1);
      if (coin(70))
        send_op(OP_LOCATE, sb.starts[k] + 32'($urandom_range(2)) - 32'd1, 12'd0);
      else
        send_op(OP_LOCATE, $urandom, 12'd0);
    end
    send_op(OP_QUERY, 32'h0, 12'd0);
    send_op(OP_QUERY, 32'h0, 12'hFFF);
    repeat (30) send_op(OP_QUERY, $urandom, 12'($urandom));
    send_op(OP_CLEAR, 32'h0, 12'd0);
    drain();
  endtask

  // Mostly ascending marks with locates and queries aimed at stored lines.
  task automatic random_phase(logic [31:0] fsz, int unsigned g, int unsigned s, int n);
    line_req_t   r;
    int unsigned sel;
    int unsigned cnt;
    gap_pct   = g;
    stall_pct = s;
    write_file_size(fsz);
    repeat (n) begin
      cnt           = sb.count;
      sel           = $urandom_range(99);
      r.position    = $urandom;
      r.line_number = 12'($urandom);
      if (sel < 3) begin
        r.op = OP_CLEAR;
      end else if (sel < 40) begin
        r.op = OP_MARK;
        if (sel < 36) begin
          if (cnt != 0) r.position = sb.starts[cnt - 1] + $urandom_range(500);
          else if (coin(50)) r.position = 32'h0;
          else if (coin(50)) r.position = $urandom_range(64);
        end
      end else if (sel < 75) begin
        r.op = OP_LOCATE;
        if (cnt != 0 && sel < 68)
          r.position = sb.starts[$urandom_range(cnt - 1)] + 32'($urandom_range(2)) - 32'd1;
      end else begin
        r.op = OP_QUERY;
        if (cnt != 0 && sel < 92) r.line_number = 12'($urandom_range(cnt - 1));
      end
      send(r);
    end
    drain();
  endtask

  initial begin
    sb          = new;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    req_valid   = 1'b0;
    op          = OP_MARK;
    position    = '0;
    line_number = '0;
    rsp_stall   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_requests();
    fill_table_phase();
    random_phase(32'h0, 0, 0, 250);
    random_phase(32'h8000_0000, 46, 0, 250);
    random_phase($urandom, 0, 46, 250);
    random_phase(32'hFFFF_FFFF, 8, 8, 250);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
